// ----- hw/rtl/brickwall_peak_limiter_assert.svh -----
// Assertion macros for the brickwall peak limiter.
// Used by the top level only; no other dependencies.
`ifndef BRICKWALL_PEAK_LIMITER_ASSERT_SVH
`define BRICKWALL_PEAK_LIMITER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BPL_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Implication checked in the cycle after the condition.
`define BPL_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hw/rtl/bpl_pkg.sv -----
// Shared constants and types for the brickwall peak limiter.
// No dependencies.
package bpl_pkg;
   localparam int MAX_DELAY_DEF     = 512;
   localparam int CHANNEL_COUNT_DEF = 2;
   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int COEF_BITS         = 23;
   localparam int CSR_IDX_BITS      = 2;
   localparam int CSR_DATA_BITS     = 24;
   localparam int LEN_BITS          = 10;

   localparam logic [CSR_IDX_BITS-1:0] REG_CEILING   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RELEASE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TRUE_PEAK = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LOOKAHEAD = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic clear_step; // zero one delay memory entry
      logic load;       // capture request, start detection
      logic tp_step;    // true-peak scale step
      logic div_init;   // start divider
      logic div_step;   // one quotient bit
      logic env_step;   // envelope update
      logic mul_step;   // output multiply
      logic out_step;   // clip and write result register
   } cmd_type;

   // Datapath status to controller.
   typedef struct packed {
      logic need_div;
      logic clear_done;
   } status_type;
endpackage

// ----- hw/rtl/bpl_ctrl.sv -----
// Sequencer for the brickwall peak limiter.
// Depends on bpl_pkg.
module bpl_ctrl
   import bpl_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       rsp_free,
   input  status_type status,
   output cmd_type    cmd
);
   localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TP    = 3'd1;
   localparam logic [2:0] ST_DIVI  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_ENV   = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;
   localparam logic [2:0] ST_CLEAR = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TP;
            end
         end
         ST_TP: begin
            cmd.tp_step = 1'b1;
            state_in    = ST_DIVI;
         end
         ST_DIVI: begin
            if (status.need_div) begin
               cmd.div_init = 1'b1;
               // quotient is below unity: SAMPLE_BITS-1 fraction bits
               cnt_in       = CNT_BITS'(SAMPLE_BITS - 1);
               state_in     = ST_DIV;
            end else begin
               state_in = ST_ENV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = ST_ENV;
            end
         end
         ST_ENV: begin
            cmd.env_step = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.out_step = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

// ----- hw/rtl/bpl_datapath.sv -----
// Datapath of the brickwall peak limiter: detection, divider, envelope,
// delay memory, output scaling and result register. Depends on bpl_pkg.
module bpl_datapath
   import bpl_pkg::*;
#(
   parameter int MAX_DELAY     = MAX_DELAY_DEF,
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic                          req_channel_index,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_clear_peak,
   input  logic [SAMPLE_BITS-1:0]        ceiling,
   input  logic [COEF_BITS-1:0]          rel_coef,
   input  logic                          tp_mode,
   input  logic [LEN_BITS-1:0]           la_len,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic                          rsp_channel_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [SAMPLE_BITS-1:0]        rsp_gain_now,
   output logic                          rsp_limiting,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_hold,
   output logic                          rsp_free
);
   localparam int SB      = SAMPLE_BITS;
   localparam int CH_BITS = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int POS_BITS = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int MEM_DEPTH = CHANNEL_COUNT * MAX_DELAY;
   localparam int ADDR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int QB      = SB + 3;      // width of 4*|x| sums
   localparam int PB      = QB + 2;      // width of 3*q
   localparam int DENB    = SB + 2;      // peak width
   localparam logic [SB-1:0] UNITY = SB'(1) << (SB - 1);
   localparam logic [LEN_BITS:0] MAXD = (LEN_BITS + 1)'(MAX_DELAY);
   localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD; // ceil(2^35 / 10)

   // channel selection, saturated to last channel
   logic [CH_BITS-1:0] ch_sel;
   always_comb begin
      if ({{(CH_BITS){1'b0}}, req_channel_index} >= (CH_BITS + 1)'(CHANNEL_COUNT)) begin
         ch_sel = CH_BITS'(CHANNEL_COUNT - 1);
      end else begin
         ch_sel = CH_BITS'(req_channel_index);
      end
   end

   // per-channel state
   logic [SB-1:0]        env_ff [CHANNEL_COUNT];
   logic signed [SB-1:0] prev_ff [CHANNEL_COUNT];
   logic [POS_BITS-1:0]  pos_ff [CHANNEL_COUNT];
   logic [SB-1:0]        peak_reg_ff;

   logic [CH_BITS-1:0]   ch_ff;
   logic signed [SB-1:0] x_ff;
   logic [PB-1:0]        q3_ff;    // 3*q
   logic                 tpq_ff;   // true-peak scaling pending
   logic [DENB-1:0]      peak_ff;
   logic                 dly_ff;   // delay in use

   // detection of q, registered as 3*q
   logic [QB-1:0] q_w, m0, m1, m2, m3;
   logic signed [QB-1:0] xs, ps;
   logic signed [SB-1:0] pv;
   always_comb begin
      pv = prev_ff[ch_sel];
      xs = QB'(req_sample_in);
      ps = QB'(pv);
      m0 = xs[QB-1] ? QB'(-xs) << 2 : QB'(xs) << 2;
      m1 = ((xs + ps) < 0) ? QB'(-(xs + ps)) << 1 : QB'(xs + ps) << 1;
      m2 = ((3 * xs + ps) < 0) ? QB'(-(3 * xs + ps)) : QB'(3 * xs + ps);
      m3 = ((xs + 3 * ps) < 0) ? QB'(-(xs + 3 * ps)) : QB'(xs + 3 * ps);
      q_w = m0;
      if (pv != '0) begin
         if (m1 > q_w) q_w = m1;
         if (m2 > q_w) q_w = m2;
         if (m3 > q_w) q_w = m3;
      end
   end

   // plain magnitude of the input sample
   logic signed [SB:0] x_ext;
   logic [SB:0]        x_abs;
   assign x_ext = {req_sample_in[SB-1], req_sample_in};
   assign x_abs = x_ext[SB] ? unsigned'(-x_ext) : unsigned'(x_ext);

   // lookahead length and positions
   logic [LEN_BITS:0]   len;
   logic [POS_BITS:0]   pos_use, pos_nx;
   always_comb begin
      len = (int'(la_len) > MAX_DELAY) ? MAXD : {1'b0, la_len};
      pos_use = {1'b0, pos_ff[ch_sel]};
      if ((LEN_BITS + 1)'(pos_use) >= len) pos_use = '0;
      pos_nx = pos_use + 1'b1;
      if ((LEN_BITS + 1)'(pos_nx) >= len) pos_nx = '0;
   end

   // delay memory: zeroed after reset, then read oldest and write the new sample
   logic signed [SB-1:0] mem [MEM_DEPTH];
   logic signed [SB-1:0] mem_rd_ff;
   logic [ADDR_BITS-1:0] addr;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   assign addr = ADDR_BITS'(ch_sel * MAX_DELAY + pos_use[POS_BITS-1:0]);
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.load && len != '0) begin
         mem_rd_ff  <= mem[addr];
         mem[addr]  <= req_sample_in;
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // 3*q/10 by reciprocal multiplication
   logic [PB+31:0]  div10_prod;
   logic [DENB-1:0] peak_tp, peak_now;
   assign div10_prod = (PB+32)'(q3_ff) * (PB+32)'(RECIP_10);
   assign peak_tp    = DENB'(div10_prod >> 35);
   assign peak_now   = tpq_ff ? peak_tp : peak_ff;

   // capture on load, peak scaling in the next step
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff   <= ch_sel;
         x_ff    <= req_sample_in;
         q3_ff   <= PB'(q_w) * PB'(3);
         tpq_ff  <= tp_mode;
         dly_ff  <= (len != '0);
         if (!tp_mode) begin
            peak_ff <= DENB'(x_abs);
         end
      end else if (cmd.tp_step && tpq_ff) begin
         peak_ff <= peak_tp;
      end
   end

   // peak hold and state updates at the true-peak step
   logic [DENB-1:0] phold;
   always_comb begin
      phold = (peak_now > DENB'({SB{1'b1}})) ? DENB'({SB{1'b1}}) : peak_now;
   end

   // restoring divider: ceiling/peak as SB-1 fraction bits, ceiling < peak
   logic            need_div;
   logic [DENB:0]   div_rem_ff;
   logic [DENB:0]   rem_sh;
   logic [SB-1:0]   div_quo_ff;
   assign need_div = (peak_ff > DENB'(ceiling));
   assign rem_sh   = {div_rem_ff[DENB-1:0], 1'b0};
   always_comb begin
      status.need_div   = need_div;
      status.clear_done = (clr_addr_ff == ADDR_BITS'(MEM_DEPTH - 1));
   end
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_rem_ff <= (DENB+1)'(ceiling);
         div_quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, peak_ff}) begin
            div_rem_ff <= rem_sh - {1'b0, peak_ff};
            div_quo_ff <= {div_quo_ff[SB-2:0], 1'b1};
         end else begin
            div_rem_ff <= rem_sh;
            div_quo_ff <= {div_quo_ff[SB-2:0], 1'b0};
         end
      end
   end

   // gain target
   logic [SB-1:0] g;
   assign g = need_div ? div_quo_ff : UNITY;

   // envelope update
   logic [SB-1:0]          env_cur, env_new;
   logic [SB+COEF_BITS-1:0] rel_prod;
   logic                   lim_w;
   always_comb begin
      env_cur  = env_ff[ch_ff];
      if (env_cur > UNITY) env_cur = UNITY;
      rel_prod = (SB+COEF_BITS)'(rel_coef) * (SB+COEF_BITS)'(UNITY - env_cur);
      lim_w    = (g < env_cur);
      if (lim_w) env_new = g;
      else       env_new = UNITY - SB'(rel_prod >> COEF_BITS);
      if (env_new < g) env_new = g;
      if (env_new > UNITY) env_new = UNITY;
   end

   logic [SB-1:0]        env_res_ff;
   logic                 lim_ff;
   logic signed [SB-1:0] s_ff;
   logic [2*SB-1:0]      prod_ff;

   // sample magnitude and scaling
   logic signed [SB:0]   s_ext;
   logic [SB:0]          s_mag;
   assign s_ext = {s_ff[SB-1], s_ff};
   assign s_mag = s_ff[SB-1] ? SB'(1'b0) - s_ext : s_ext;

   always_ff @(posedge clock) begin
      if (cmd.env_step) begin
         env_res_ff <= env_new;
         lim_ff     <= lim_w;
         s_ff       <= dly_ff ? mem_rd_ff : x_ff;
      end
      if (cmd.mul_step) begin
         prod_ff <= (2*SB)'(s_mag) * (2*SB)'(env_res_ff);
      end
   end

   // clip bounds
   logic signed [SB+1:0] y, hi, lo, mm;
   always_comb begin
      mm = (SB+2)'(prod_ff >> (SB - 1));
      y  = s_ff[SB-1] ? -mm : mm;
      hi = (ceiling < UNITY - 1'b1) ? (SB+2)'(ceiling) : (SB+2)'(UNITY - 1'b1);
      lo = (ceiling < UNITY) ? -(SB+2)'(ceiling) : -(SB+2)'(UNITY);
      if (y > hi) y = hi;
      if (y < lo) y = lo;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            env_ff[i]  <= UNITY;
            prev_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
         peak_reg_ff <= '0;
      end else begin
         if (cmd.load) begin
            if (tp_mode) prev_ff[ch_sel] <= req_sample_in;
            if (len != '0) pos_ff[ch_sel] <= pos_nx[POS_BITS-1:0];
            if (req_clear_peak) peak_reg_ff <= '0;
         end
         if (cmd.tp_step && DENB'(phold) > DENB'(peak_reg_ff)) begin
            peak_reg_ff <= phold[SB-1:0];
         end
         if (cmd.env_step) env_ff[ch_ff] <= env_new;
      end
   end

   // result register
   logic rv_ff;
   assign rsp_free  = !rv_ff || !rsp_stall;
   assign rsp_valid = rv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.out_step) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.out_step) begin
         rsp_channel_out <= ch_ff[0];
         rsp_sample_out  <= y[SB-1:0];
         rsp_gain_now    <= env_res_ff;
         rsp_limiting    <= lim_ff;
         rsp_peak_hold   <= peak_reg_ff;
      end
   end
endmodule

// ----- hw/rtl/brickwall_peak_limiter.sv -----
// Top level of the brickwall peak limiter: registers, sequencer, datapath.
// Depends on bpl_pkg, bpl_ctrl, bpl_datapath and the assertion header.
//
// Usage: requests enter on req_* (valid/stall); one result per request
// leaves on rsp_* (valid/stall). Configuration is written on csr_* while
// the block is idle; csr_ready is always high.
// Each request passes the true-peak step, the divider check, the envelope,
// multiply and output steps; when the peak exceeds the ceiling the target
// gain needs the divider, which retires one of 23 quotient bits per cycle. One
// request is in flight at a time; the next is taken after the output step.
// Reset clears the registers to their defaults, envelopes to unity,
// previous samples, delay positions and the peak hold to zero. After
// reset the delay memory is zeroed one entry per cycle, all 1024 entries at
// the default size, with req_stall held high.
// A stalled receiver holds the result register; one more request can be
// taken and waits at the output step, req_stall high, until it frees.
`include "brickwall_peak_limiter_assert.svh"
module brickwall_peak_limiter
   import bpl_pkg::*;
#(
   parameter int MAX_DELAY     = MAX_DELAY_DEF,
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_channel_index,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_clear_peak,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_channel_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [SAMPLE_BITS-1:0]        rsp_gain_now,
   output logic                          rsp_limiting,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_hold,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);
   logic [SAMPLE_BITS-1:0] ceiling_ff;
   logic [COEF_BITS-1:0]   rel_ff;
   logic                   tp_ff;
   logic [LEN_BITS-1:0]    len_ff;
   cmd_type                cmd;
   status_type             status;
   logic                   rsp_free;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
         rel_ff     <= COEF_BITS'(8386861);
         tp_ff      <= 1'b0;
         len_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CEILING:   ceiling_ff <= SAMPLE_BITS'(csr_data);
            REG_RELEASE:   rel_ff     <= csr_data[COEF_BITS-1:0];
            REG_TRUE_PEAK: tp_ff      <= csr_data[0];
            REG_LOOKAHEAD: len_ff     <= csr_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   bpl_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_free, .status, .cmd
   );

   bpl_datapath #(
      .MAX_DELAY(MAX_DELAY), .CHANNEL_COUNT(CHANNEL_COUNT), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .status,
      .req_channel_index, .req_sample_in, .req_clear_peak,
      .ceiling(ceiling_ff), .rel_coef(rel_ff), .tp_mode(tp_ff), .la_len(len_ff),
      .rsp_stall, .rsp_valid, .rsp_channel_out, .rsp_sample_out, .rsp_gain_now,
      .rsp_limiting, .rsp_peak_hold, .rsp_free
   );

   // busy follows an accepted request, gain stays at most unity, one step at a time
   `BPL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "busy not raised after accept")
   `BPL_ASSERT_IMPL(a_gain_range, clock, reset, rsp_valid, rsp_gain_now <= (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1)), "gain above unity")
   `BPL_ASSERT_IMPL(a_one_step, clock, reset, 1'b1, $countones({cmd.clear_step, cmd.load, cmd.div_step, cmd.env_step, cmd.mul_step, cmd.out_step}) <= 1, "overlapping commands")
endmodule

// ----- dv/brickwall_peak_limiter_test.sv -----
// Self-checking testbench for brickwall_peak_limiter: directed, special-case,
// random and backpressure tests against a built-in predictor of the limiter.
// Depends on bpl_pkg and the brickwall_peak_limiter RTL.
`timescale 1ns / 1ps
module brickwall_peak_limiter_test
   import bpl_pkg::*;
();

   localparam longint UNITY     = 64'd1 << 23;
   localparam int     DELAY_MAX = 512;

   typedef struct {
      bit          channel;
      logic [23:0] sample;
      logic [23:0] gain;
      bit          limiting;
      logic [23:0] peak;
   } limiter_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_channel_index = 1'b0;
   logic signed [23:0]       req_sample_in = '0;
   logic                     req_clear_peak = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_channel_out;
   logic signed [23:0]       rsp_sample_out;
   logic [23:0]              rsp_gain_now;
   logic                     rsp_limiting;
   logic [23:0]              rsp_peak_hold;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = REG_CEILING;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // Predictor state: configuration and per-channel limiter state
   longint ceiling_reg;
   longint release_reg;
   bit     true_peak_reg;
   longint lookahead_reg;
   longint env_gain [2];
   longint prev_smp [2];
   longint delay_mem [2][DELAY_MAX];
   int     delay_pos [2];
   longint peak_reg;

   limiter_out_type expected_q[$];
   int  mismatch_count = 0;
   bit  failed = 1'b0;
   bit  idle_enable = 1'b1;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   always #2 clock = ~clock;

   brickwall_peak_limiter i_dut (.*);

   // Reference limiter: computes the result for one accepted request
   function automatic limiter_out_type limit_sample(bit ch, logic signed [23:0] smp, bit clr);
      limiter_out_type r;
      longint x, p, q, pk, g, env, s, m, y, hi, lo, len;
      int pos;
      x = smp;
      if (true_peak_reg) begin
         p = prev_smp[ch];
         q = 4 * (x < 0 ? -x : x);
         if (p != 0) begin
            if ((2*x + 2*p) > q) q = 2*x + 2*p;
            if (-(2*x + 2*p) > q) q = -(2*x + 2*p);
            if ((3*x + p) > q) q = 3*x + p;
            if (-(3*x + p) > q) q = -(3*x + p);
            if ((x + 3*p) > q) q = x + 3*p;
            if (-(x + 3*p) > q) q = -(x + 3*p);
         end
         prev_smp[ch] = x;
         pk = (q * 3) / 10;
      end else begin
         pk = x < 0 ? -x : x;
      end
      if (clr) peak_reg = 0;
      if (pk > peak_reg) peak_reg = pk > 64'hFFFFFF ? 64'hFFFFFF : pk;

      g = pk > ceiling_reg ? (ceiling_reg << 23) / pk : UNITY;
      env = env_gain[ch] > UNITY ? UNITY : env_gain[ch];
      r.limiting = 1'b0;
      if (g < env) begin
         env = g;
         r.limiting = 1'b1;
      end else begin
         env = UNITY - ((release_reg * (UNITY - env)) >>> 23);
      end
      if (env < g) env = g;
      if (env > UNITY) env = UNITY;
      env_gain[ch] = env;

      // Lookahead delay line, per channel
      len = lookahead_reg > DELAY_MAX ? DELAY_MAX : lookahead_reg;
      if (len > 0) begin
         pos = delay_pos[ch];
         if (pos >= len) pos = 0;
         s = delay_mem[ch][pos];
         delay_mem[ch][pos] = x;
         pos++;
         if (pos >= len) pos = 0;
         delay_pos[ch] = pos;
      end else begin
         s = x;
      end

      m = ((s < 0 ? -s : s) * env) >>> 23;
      y = s < 0 ? -m : m;
      hi = ceiling_reg < UNITY - 1 ? ceiling_reg : UNITY - 1;
      lo = -(ceiling_reg < UNITY ? ceiling_reg : UNITY);
      if (y > hi) y = hi;
      if (y < lo) y = lo;

      r.channel = ch;
      r.sample  = y[23:0];
      r.gain    = env[23:0];
      r.peak    = peak_reg[23:0];
      return r;
   endfunction

   // Send one request; valid stays high until the next gap
   task automatic send_request(bit ch, logic signed [23:0] smp, bit clr);
      if (idle_enable && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_channel_index <= ch;
      req_sample_in     <= smp;
      req_clear_peak    <= clr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(limit_sample(ch, smp, clr));
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let all outstanding requests drain, then allow the block to settle
   task automatic drain();
      stop_requests();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Write all four registers back to back
   task automatic configure(longint ceil, longint rel, bit tp, longint la);
      logic [CSR_IDX_BITS-1:0]  idx [4];
      logic [CSR_DATA_BITS-1:0] val [4];
      idx = '{REG_CEILING, REG_RELEASE, REG_TRUE_PEAK, REG_LOOKAHEAD};
      val = '{ceil[23:0], rel[23:0], {23'd0, tp}, la[23:0]};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      ceiling_reg   = ceil & 64'hFFFFFF;
      release_reg   = rel & 64'h7FFFFF;
      true_peak_reg = tp;
      lookahead_reg = la & 64'h3FF;
   endtask

   function automatic logic signed [23:0] rand_sample();
      logic signed [23:0] v;
      case ($urandom_range(3))
         0: v = 24'($urandom());
         1: begin
            v = 24'($urandom_range(8388607, 5000000));
            if ($urandom_range(1)) v = -v;
         end
         2: v = $signed(24'($urandom_range(4000))) - 24'sd2000;
         default: v = $urandom_range(1) ? 24'sh800000 : 24'sh7FFFFF;
      endcase
      return v;
   endfunction

   // Receiver: random stall, or a long hold when asked
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 300;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(99) < 30);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      limiter_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: ch %0d sample %0d", rsp_channel_out,
                        rsp_sample_out);
         end else begin
            e = expected_q.pop_front();
            if (rsp_channel_out !== e.channel || rsp_sample_out !== e.sample ||
                rsp_gain_now !== e.gain || rsp_limiting !== e.limiting ||
                rsp_peak_hold !== e.peak) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp ch %0d smp %h gain %h lim %0d peak %h / got ch %0d smp %h gain %h lim %0d peak %h",
                           e.channel, e.sample, e.gain, e.limiting, e.peak,
                           rsp_channel_out, rsp_sample_out, rsp_gain_now,
                           rsp_limiting, rsp_peak_hold);
            end
         end
      end
   end

   // Field extremes, both channels, peak clear, under reset and then low-ceiling settings
   task automatic test_directed();
      send_request(1'b0, 24'sh000000, 1'b0);
      send_request(1'b0, 24'sh7FFFFF, 1'b0);
      send_request(1'b1, 24'sh800000, 1'b0);
      send_request(1'b1, -24'sd1, 1'b1);
      send_request(1'b0, 24'sd1, 1'b0);
      send_request(1'b0, 24'sh555555, 1'b1);
      send_request(1'b1, 24'shAAAAAA, 1'b0);
      drain();
      // low ceiling, true peak, short lookahead: instant attack then release
      configure(7476354, 8388607, 1'b1, 3);
      send_request(1'b0, 24'sh7FFFFF, 1'b0);
      send_request(1'b0, 24'sh800000, 1'b0);
      send_request(1'b1, 24'sh600000, 1'b0);
      send_request(1'b1, 24'sh600000, 1'b0);
      send_request(1'b0, 24'sd100, 1'b0);
      send_request(1'b0, 24'sd0, 1'b1);
      send_request(1'b1, -24'sd5000000, 1'b0);
      send_request(1'b0, 24'sd0, 1'b0);
      drain();
   endtask

   // Zero and above-unity ceiling, lookahead saturation and shrink
   task automatic test_special_cases();
      configure(0, 0, 1'b0, 1023);
      for (int i = 0; i < 6; i++) send_request(i[0], rand_sample(), 1'b0);
      drain();
      configure(24'hFFFFFF, 4194304, 1'b1, 8);
      for (int i = 0; i < 12; i++) send_request(i[0], rand_sample(), 1'b0);
      drain();
      configure(8388608, 8386861, 1'b0, 2);
      for (int i = 0; i < 8; i++) send_request(i[0], rand_sample(), i == 3);
      drain();
   endtask

   // Random phases over a spread of settings
   task automatic test_random();
      longint ceil, rel, la;
      for (int ph = 0; ph < 16; ph++) begin
         idle_enable = (ph != 5);
         case (ph % 4)
            0: ceil = 7476354;
            1: ceil = 8388608;
            2: ceil = $urandom_range(8388608, 7476354);
            default: ceil = $urandom_range(8388608, 6000000);
         endcase
         case (ph % 3)
            0: rel = 0;
            1: rel = 8388607;
            default: rel = $urandom_range(8388607, 8000000);
         endcase
         la = (ph == 7) ? 512 : $urandom_range(16);
         configure(ceil, rel, 1'($urandom_range(1)), la);
         for (int i = 0; i < 95; i++)
            send_request(1'($urandom_range(1)), rand_sample(), $urandom_range(99) < 5);
         drain();
      end
      idle_enable = 1'b1;
   endtask

   // Long receiver hold while requests keep coming
   task automatic test_backpressure();
      configure(7476354, 8300000, 1'b1, 4);
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) send_request(i[0], rand_sample(), 1'b0);
      drain();
   endtask

   initial begin
      ceiling_reg = 8388608; release_reg = 8386861; true_peak_reg = 0; lookahead_reg = 0;
      peak_reg = 0;
      for (int c = 0; c < 2; c++) begin
         env_gain[c] = UNITY;
         prev_smp[c] = 0;
         delay_pos[c] = 0;
         for (int k = 0; k < DELAY_MAX; k++) delay_mem[c][k] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_special_cases();
      test_random();
      test_backpressure();
      if (!failed && mismatch_count == 0)
         $display("PASS brickwall_peak_limiter");
      else
         $display("FAIL brickwall_peak_limiter");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("FAIL brickwall_peak_limiter");
      $finish;
   end
endmodule
